// ----- hdl/hpq_pkg.sv -----
// ----------------------------------------------------------------------------
// hpq_pkg
// Shared widths, item codes and status codes for the max-heap queue.
// ----------------------------------------------------------------------------
package hpq_pkg;

    localparam int VALUE_W     = 32;
    localparam int FILL_W      = 7;
    localparam int OUT_TDATA_W = ((VALUE_W + FILL_W + 7) / 8) * 8;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

endpackage

// ----- hdl/max_heap_priority_queue.sv -----
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Binary max-heap of signed values with insert and remove-max items.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                          tuser
//  s_        in   value[31:0]                    opcode
//  m_        out  max_value[31:0], fill[38:32]   status[1:0]
//
//  Each item runs to its end before the next is accepted: an insert sifts
//  the value up from the new last slot; a remove takes the root and sifts
//  the last entry down from the root. An insert when full or a remove when
//  empty goes straight to the result with a FULL or EMPTY status.
//  Reset empties the heap at once; no clearing pass.
//  A result waiting on m_tready holds the next result in its last state.
// ----------------------------------------------------------------------------
module max_heap_priority_queue #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [hpq_pkg::VALUE_W-1:0]     s_tdata,   // value
    input  logic                           s_tuser,   // opcode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [hpq_pkg::OUT_TDATA_W-1:0] m_tdata,   // max_value, fill_count
    output logic [1:0]                     m_tuser    // status
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_DEL_RD,
        S_DN_RD,
        S_DN_CMP,
        S_DONE
    } state_t;

    state_t                        state_reg, state_next;
    logic [AW-1:0]                 pos_reg, pos_next;
    logic signed [DATA_WIDTH-1:0]  val_reg, val_next;
    logic signed [DATA_WIDTH-1:0]  res_reg, res_next;
    logic [CW-1:0]                 cnt_reg, cnt_next;
    hpq_pkg::status_t              stat_reg, stat_next;
    logic                          rc_ok_reg, rc_ok_next;
    logic                          m_valid_reg, m_valid_next;
    logic [hpq_pkg::VALUE_W-1:0]   m_max_reg, m_max_next;
    logic [hpq_pkg::FILL_W-1:0]    m_fill_reg, m_fill_next;
    hpq_pkg::status_t              m_stat_reg, m_stat_next;

    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [DATA_WIDTH-1:0]         wr_data;
    logic [AW-1:0]                 rd0_addr, rd1_addr;
    logic [DATA_WIDTH-1:0]         rd0_data, rd1_data;

    logic                          s_fire;
    logic                          full;
    logic [IW-1:0]                 lc_idx, rc_idx, cnt_ext;
    logic [AW-1:0]                 parent_idx;
    logic signed [DATA_WIDTH-1:0]  in_val, lc_val, rc_val, child_val;
    logic                          pick_rc;

    hpq_mem #(
        .DEPTH(CAPACITY),
        .WIDTH(DATA_WIDTH)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd0_addr(rd0_addr),
        .rd0_data(rd0_data),
        .rd1_addr(rd1_addr),
        .rd1_data(rd1_data)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign full     = (cnt_reg == CW'(CAPACITY));
    assign in_val   = DATA_WIDTH'($signed(s_tdata));

    assign cnt_ext    = IW'(cnt_reg);
    assign lc_idx     = IW'({pos_reg, 1'b1});
    assign rc_idx     = lc_idx + IW'(1);
    assign parent_idx = AW'((pos_reg - AW'(1)) >> 1);

    assign lc_val    = $signed(rd0_data);
    assign rc_val    = $signed(rd1_data);
    assign pick_rc   = rc_ok_reg && (rc_val > lc_val);
    assign child_val = pick_rc ? rc_val : lc_val;

    always_comb begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        val_next     = val_reg;
        res_next     = res_reg;
        cnt_next     = cnt_reg;
        stat_next    = stat_reg;
        rc_ok_next   = rc_ok_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_max_next   = m_max_reg;
        m_fill_next  = m_fill_reg;
        m_stat_next  = m_stat_reg;
        wr_en        = 1'b0;
        wr_addr      = pos_reg;
        wr_data      = val_reg;
        rd0_addr     = '0;
        rd1_addr     = '0;

        unique case (state_reg)
            S_IDLE: begin
                rd0_addr = '0;
                rd1_addr = (cnt_reg == '0) ? '0 : AW'(cnt_reg - CW'(1));
                if (s_fire) begin
                    res_next  = '0;
                    stat_next = hpq_pkg::ST_DONE;
                    if (s_tuser == hpq_pkg::OP_INSERT) begin
                        if (full) begin
                            stat_next  = hpq_pkg::ST_FULL;
                            state_next = S_DONE;
                        end else begin
                            val_next   = in_val;
                            pos_next   = AW'(cnt_reg);
                            cnt_next   = cnt_reg + CW'(1);
                            state_next = S_UP_RD;
                        end
                    end else begin
                        if (cnt_reg == '0) begin
                            stat_next  = hpq_pkg::ST_EMPTY;
                            state_next = S_DONE;
                        end else begin
                            cnt_next   = cnt_reg - CW'(1);
                            state_next = S_DEL_RD;
                        end
                    end
                end
            end
            S_UP_RD: begin
                rd0_addr = parent_idx;
                if (pos_reg == '0) begin
                    wr_en      = 1'b1;
                    state_next = S_DONE;
                end else begin
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                // parent data is in rd0_data
                if (lc_val < val_reg) begin
                    wr_en      = 1'b1;
                    wr_data    = rd0_data;
                    pos_next   = parent_idx;
                    state_next = S_UP_RD;
                end else begin
                    wr_en      = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DEL_RD: begin
                res_next = lc_val;
                val_next = rc_val;
                pos_next = '0;
                if (cnt_reg == '0) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_DN_RD;
                end
            end
            S_DN_RD: begin
                rd0_addr   = AW'(lc_idx);
                rd1_addr   = (rc_idx < cnt_ext) ? AW'(rc_idx) : AW'(lc_idx);
                rc_ok_next = (rc_idx < cnt_ext);
                if (lc_idx < cnt_ext) begin
                    state_next = S_DN_CMP;
                end else begin
                    wr_en      = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DN_CMP: begin
                if (child_val > val_reg) begin
                    wr_en      = 1'b1;
                    wr_data    = child_val;
                    pos_next   = pick_rc ? AW'(rc_idx) : AW'(lc_idx);
                    state_next = S_DN_RD;
                end else begin
                    wr_en      = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_max_next   = hpq_pkg::VALUE_W'(res_reg);
                    m_fill_next  = hpq_pkg::FILL_W'(cnt_reg);
                    m_stat_next  = stat_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        res_reg    <= res_next;
        stat_reg   <= stat_next;
        rc_ok_reg  <= rc_ok_next;
        m_max_reg  <= m_max_next;
        m_fill_reg <= m_fill_next;
        m_stat_reg <= m_stat_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = hpq_pkg::OUT_TDATA_W'({m_fill_reg, m_max_reg});
    assign m_tuser  = m_stat_reg;

endmodule

// ----- hdl/hpq_mem.sv -----
// ----------------------------------------------------------------------------
// hpq_mem
// Heap store: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module hpq_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd0_addr,
    output logic [WIDTH-1:0]         rd0_data,
    input  logic [$clog2(DEPTH)-1:0] rd1_addr,
    output logic [WIDTH-1:0]         rd1_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd0_data <= mem[rd0_addr];
        rd1_data <= mem[rd1_addr];
    end

endmodule
